// ===== src/binary_to_decimal_ascii_top_defines.svh =====
// Assertion macros used by the checker of the binary to decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define BDA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define BDA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/bda_pkg.sv =====
// Types, constants and helper functions of the binary to decimal ASCII converter.
package bda_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned StepW     = $clog2(ValueW);
  localparam int unsigned DigitIdxW = $clog2(NumDigits);
  localparam int unsigned CharW     = 6;
  localparam int unsigned OutDataW  = 8;

  localparam logic [CharW-1:0] AsciiZero = CharW'(48);

  // Request handed from the input queue to the conversion engine.
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
  } bda_req_t;

  // Add three to every BCD digit of five or more, ahead of the doubling shift.
  function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] bcd);
    logic [BcdW-1:0] res;
    res = bcd;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

  // Position of the highest nonzero digit; the units digit when all are zero.
  function automatic logic [DigitIdxW-1:0] top_digit(input logic [BcdW-1:0] bcd);
    logic [DigitIdxW-1:0] top;
    top = '0;
    for (int d = 1; d < NumDigits; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        top = DigitIdxW'(d);
      end
    end
    return top;
  endfunction

endpackage

// ===== src/bda_queue.sv =====
// Input stage: takes requests from the slave stream into a short queue.
module bda_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bda_pkg::ValueW-1:0] in_value_i,
  output bda_pkg::bda_req_t         req_o,
  input  logic                      req_ready_i
);
  import bda_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [ValueW-1:0] mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign in_ready_o  = (count_q != CntW'(Depth));
  assign push        = in_valid_i && in_ready_o;
  assign req_o.valid = (count_q != '0);
  assign req_o.value = mem_q[rd_ptr_q];
  assign pop         = req_o.valid && req_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_value_i;
    end
  end

endmodule

// ===== src/bda_engine.sv =====
// Conversion engine: serial double dabble, then digit emission with leading zeros dropped.
module bda_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bda_pkg::bda_req_t           req_i,
  output logic                        req_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bda_pkg::CharW-1:0]   out_char_o,
  output logic                        out_last_o
);
  import bda_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  state_e                state_q;
  logic [ValueW-1:0]     shift_q;
  logic [BcdW-1:0]       bcd_q;
  logic [BcdW-1:0]       bcd_adj;
  logic [BcdW-1:0]       bcd_d;
  logic [StepW-1:0]      step_q;
  logic [DigitIdxW-1:0]  idx_q;
  logic                  out_valid_q;
  logic [CharW-1:0]      out_char_q;
  logic                  out_last_q;
  logic [3:0]            cur_digit;
  logic                  out_free;
  logic                  emit;

  assign bcd_adj     = bcd_adjust(bcd_q);
  assign bcd_d       = {bcd_adj[BcdW-2:0], shift_q[ValueW-1]};
  assign cur_digit   = bcd_q[{idx_q, 2'b00} +: 4];
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = (state_q == StEmit) && out_free;
  assign req_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      shift_q     <= '0;
      bcd_q       <= '0;
      step_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            shift_q <= req_i.value;
            bcd_q   <= '0;
            step_q  <= '0;
            state_q <= StConv;
          end
        end
        StConv: begin
          bcd_q   <= bcd_d;
          shift_q <= {shift_q[ValueW-2:0], 1'b0};
          step_q  <= step_q + 1'b1;
          if (step_q == StepW'(ValueW - 1)) begin
            idx_q   <= top_digit(bcd_d);
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_char_q <= AsciiZero + CharW'(cur_digit);
            out_last_q <= (idx_q == '0);
            if (idx_q == '0) begin
              state_q <= StIdle;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== src/binary_to_decimal_ascii_top.sv =====
// Top level of the binary to decimal ASCII converter.
// Each 32-bit unsigned request on the slave stream becomes its decimal text, one ASCII digit per
// master-stream transfer, most significant digit first, leading zeros dropped ('0' for zero),
// with tlast on the units digit. A request passes through the queue to the engine, which shifts the
// input bits through the single shift-and-add-3 unit one at a time and then emits one digit per
// master-stream transfer, waiting while the master side stalls; the engine handles one request at a
// time, and the queue of QueueDepth requests takes new input while it works.
module binary_to_decimal_ascii_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] digit_char, [7:6] zero
  output logic        m_axis_tlast    // last_digit
);
  import bda_pkg::*;

  bda_req_t         req;
  logic             req_ready;
  logic [CharW-1:0] out_char;

  bda_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_value_i (s_axis_tdata),
    .req_o      (req),
    .req_ready_i(req_ready)
  );

  bda_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .req_ready_o(req_ready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_char_o (out_char),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {(OutDataW - CharW)'(0), out_char};

endmodule

// ===== src/bda_checker.sv =====
// Port-level checker for the binary to decimal ASCII converter, with its bind statement.
`include "binary_to_decimal_ascii_top_defines.svh"

module bda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_i,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_i,
  input logic       m_axis_tlast_i
);

  logic at_start_q;
  logic digit_ok;
  logic lead_zero;
  logic stalled;

  // High while the next digit on the master side opens a new number.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
    end else if (m_axis_tvalid_i && m_axis_tready_i) begin
      at_start_q <= m_axis_tlast_i;
    end
  end

  assign digit_ok  = (m_axis_tdata_i[7:6] == 2'b00) && (m_axis_tdata_i[5:0] >= 6'd48)
                     && (m_axis_tdata_i[5:0] <= 6'd57);
  assign lead_zero = m_axis_tvalid_i && at_start_q && (m_axis_tdata_i[5:0] == 6'd48);
  assign stalled   = m_axis_tvalid_i && !m_axis_tready_i;

  `BDA_ASSERT_ALWAYS(a_no_output_in_reset, !rst_ni |-> !m_axis_tvalid_i, "digit shown in reset")
  `BDA_ASSERT(a_digit_range, m_axis_tvalid_i |-> digit_ok, "character is not a decimal digit")
  `BDA_ASSERT(a_no_leading_zero, lead_zero |-> m_axis_tlast_i, "leading zero emitted")
  `BDA_ASSERT(a_valid_holds, stalled |=> m_axis_tvalid_i, "digit withdrawn while stalled")

endmodule

bind binary_to_decimal_ascii_top bda_checker u_bda_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_i(m_axis_tvalid),
  .m_axis_tready_i(m_axis_tready),
  .m_axis_tdata_i (m_axis_tdata),
  .m_axis_tlast_i (m_axis_tlast)
);
